FILE: sv/sector_cache_clock_replacement_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sector cache
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_TOP_ASSERT_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define SCCR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sccr assertion failed");

// Condition that must never be true outside reset.
`define SCCR_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sccr forbidden condition seen");

`else

`define SCCR_ASSERT(label, clk, rst, prop)
`define SCCR_NEVER(label, clk, rst, cond)

`endif

`endif

FILE: sv/sccr_pkg.sv
// ----------------------------------------------------------------------------
// sccr_pkg
// Types, sizes and codes shared by the sector cache modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sccr_pkg;

   localparam int ENTRIES     = 64;
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int CNT_W       = $clog2(ENTRIES + 1);
   localparam int MAX_RESULTS = 64;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int SECTOR_W    = 32;
   localparam int SLOT_W      = 6;
   localparam int PIN_W       = 8;
   localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

   typedef enum logic [1:0] {
      FUNC_LOOKUP    = 2'd0,
      FUNC_RELEASE   = 2'd1,
      FUNC_FLUSH     = 2'd2,
      FUNC_FLUSH_INV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_ALL_PINNED   = 2'd1,
      STATUS_RELEASE_MISS = 2'd2
   } status_type;

   typedef struct packed {
      func_type              func;
      logic [SECTOR_W-1:0]   sector;
      logic                  mark_dirty;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_W-1:0]     slot;
      logic                  fill_needed;
      logic                  writeback_valid;
      logic [SECTOR_W-1:0]   writeback_sector;
      status_type            status;
      logic                  last;
   } result_type;

   // One word of the tag memory: tag plus per-entry metadata.
   typedef struct packed {
      logic [SECTOR_W-1:0]   tag;
      logic [PIN_W-1:0]      pin;
      logic                  accessed;
      logic                  dirty;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: sv/sccr_ram.sv
// ----------------------------------------------------------------------------
// sccr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sccr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/sccr_rsp_reg.sv
// ----------------------------------------------------------------------------
// sccr_rsp_reg
// Output register that decouples the controller from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sccr_rsp_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire sccr_pkg::result_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output sccr_pkg::result_type      out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   sccr_pkg::result_type data_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: sv/sccr_ctrl.sv
// ----------------------------------------------------------------------------
// sccr_ctrl
// Sequencer that scans the tag memory for lookup, release, victim and flush.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sector_cache_clock_replacement_top_assert.svh"

module sccr_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire sccr_pkg::req_type                 req_item,
   output logic                                   emit_valid,
   input  wire logic                              emit_ready,
   output sccr_pkg::result_type                   emit_data,
   output logic                                   mem_wr_en,
   output logic [sccr_pkg::IDX_W-1:0]             mem_wr_addr,
   output logic [sccr_pkg::ENTRY_W-1:0]           mem_wr_data,
   output logic                                   mem_rd_en,
   output logic [sccr_pkg::IDX_W-1:0]             mem_rd_addr,
   input  wire logic [sccr_pkg::ENTRY_W-1:0]      mem_rd_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LK_READ,
      S_LK_CHK,
      S_VS_READ,
      S_VS_CHK,
      S_FL_READ,
      S_FL_CHK,
      S_FL_END,
      S_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   sccr_pkg::req_type                 item_ff, item_in;
   logic [sccr_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic [sccr_pkg::CNT_W-1:0]        used_ff, used_in;
   logic [sccr_pkg::ENTRIES-1:0]      valid_ff, valid_in;
   logic                              pass_ff, pass_in;
   logic [sccr_pkg::RES_CNT_W-1:0]    k_ff, k_in;
   logic                              remain_ff, remain_in;
   logic                              pend_ff, pend_in;
   sccr_pkg::result_type              res_ff, res_in;
   logic                              rd_valid_ff;

   sccr_pkg::entry_type               rd_ent;
   sccr_pkg::entry_type               wr_ent;
   sccr_pkg::entry_type               new_ent;
   logic [sccr_pkg::IDX_W-1:0]        cur_idx;
   logic                              is_lookup;

   assign cur_idx   = idx_ff[sccr_pkg::IDX_W-1:0];
   assign is_lookup = (item_ff.func == sccr_pkg::FUNC_LOOKUP);
   assign req_ready = (state_ff == S_IDLE);

   // Metadata of an entry whose valid bit is clear reads as zero.
   always_comb begin
      rd_ent = sccr_pkg::entry_type'(mem_rd_data);
      if (!rd_valid_ff) begin
         rd_ent.pin      = '0;
         rd_ent.accessed = 1'b0;
         rd_ent.dirty    = 1'b0;
      end
   end

   always_comb begin
      new_ent.tag      = item_ff.sector;
      new_ent.pin      = sccr_pkg::PIN_W'(1);
      new_ent.accessed = 1'b1;
      new_ent.dirty    = item_ff.mark_dirty;
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      idx_in    = idx_ff;
      used_in   = used_ff;
      valid_in  = valid_ff;
      pass_in   = pass_ff;
      k_in      = k_ff;
      remain_in = remain_ff;
      pend_in   = pend_ff;
      res_in    = res_ff;
      wr_ent    = rd_ent;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cur_idx;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cur_idx;
      emit_valid  = 1'b0;
      emit_data   = res_ff;
      emit_data.last = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in   = req_item;
               idx_in    = '0;
               k_in      = '0;
               remain_in = 1'b0;
               pend_in   = 1'b0;
               pass_in   = 1'b0;
               res_in    = '0;
               if (req_item.func == sccr_pkg::FUNC_LOOKUP ||
                   req_item.func == sccr_pkg::FUNC_RELEASE) begin
                  state_in = S_LK_READ;
               end else begin
                  state_in = S_FL_READ;
               end
            end
         end

         S_LK_READ: begin
            if (idx_ff == used_ff) begin
               res_in = '0;
               if (!is_lookup) begin
                  res_in.status = sccr_pkg::STATUS_RELEASE_MISS;
                  state_in      = S_EMIT;
               end else if (used_ff != sccr_pkg::CNT_W'(sccr_pkg::ENTRIES)) begin
                  // Free slot left: fill in slot order.
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = used_ff[sccr_pkg::IDX_W-1:0];
                  wr_ent      = new_ent;
                  valid_in[used_ff[sccr_pkg::IDX_W-1:0]] = 1'b1;
                  used_in     = used_ff + sccr_pkg::CNT_W'(1);
                  res_in.slot        = sccr_pkg::SLOT_W'(used_ff);
                  res_in.fill_needed = 1'b1;
                  state_in    = S_EMIT;
               end else begin
                  idx_in   = '0;
                  state_in = S_VS_READ;
               end
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_LK_CHK;
            end
         end

         S_LK_CHK: begin
            if (rd_ent.tag == item_ff.sector) begin
               mem_wr_en = 1'b1;
               if (is_lookup) begin
                  if (rd_ent.pin != sccr_pkg::PIN_MAX) begin
                     wr_ent.pin = rd_ent.pin + sccr_pkg::PIN_W'(1);
                  end
                  wr_ent.accessed = 1'b1;
                  wr_ent.dirty    = rd_ent.dirty | item_ff.mark_dirty;
               end else if (rd_ent.pin != '0) begin
                  wr_ent.pin = rd_ent.pin - sccr_pkg::PIN_W'(1);
               end
               res_in      = '0;
               res_in.hit  = 1'b1;
               res_in.slot = sccr_pkg::SLOT_W'(cur_idx);
               state_in    = S_EMIT;
            end else begin
               idx_in   = idx_ff + sccr_pkg::CNT_W'(1);
               state_in = S_LK_READ;
            end
         end

         S_VS_READ: begin
            mem_rd_en = 1'b1;
            state_in  = S_VS_CHK;
         end

         S_VS_CHK: begin
            if (rd_ent.pin == '0 && !rd_ent.accessed) begin
               mem_wr_en = 1'b1;
               wr_ent    = new_ent;
               valid_in[cur_idx] = 1'b1;
               res_in             = '0;
               res_in.slot        = sccr_pkg::SLOT_W'(cur_idx);
               res_in.fill_needed = 1'b1;
               if (rd_ent.dirty) begin
                  res_in.writeback_valid  = 1'b1;
                  res_in.writeback_sector = rd_ent.tag;
               end
               state_in = S_EMIT;
            end else begin
               if (rd_ent.pin == '0) begin
                  // Second chance: clear the accessed bit and move on.
                  mem_wr_en       = 1'b1;
                  wr_ent.accessed = 1'b0;
               end
               if (idx_ff == sccr_pkg::CNT_W'(sccr_pkg::ENTRIES - 1)) begin
                  if (pass_ff) begin
                     res_in        = '0;
                     res_in.status = sccr_pkg::STATUS_ALL_PINNED;
                     state_in      = S_EMIT;
                  end else begin
                     pass_in  = 1'b1;
                     idx_in   = '0;
                     state_in = S_VS_READ;
                  end
               end else begin
                  idx_in   = idx_ff + sccr_pkg::CNT_W'(1);
                  state_in = S_VS_READ;
               end
            end
         end

         S_FL_READ: begin
            if (idx_ff == used_ff) begin
               state_in = S_FL_END;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_FL_CHK;
            end
         end

         S_FL_CHK: begin
            if (!rd_ent.dirty) begin
               idx_in   = idx_ff + sccr_pkg::CNT_W'(1);
               state_in = S_FL_READ;
            end else if (k_ff == sccr_pkg::RES_CNT_W'(sccr_pkg::MAX_RESULTS)) begin
               remain_in = 1'b1;
               state_in  = S_FL_END;
            end else begin
               // A new dirty entry proves the held result is not the last one.
               emit_valid = pend_ff;
               if (!pend_ff || emit_ready) begin
                  mem_wr_en    = 1'b1;
                  wr_ent.dirty = 1'b0;
                  res_in                  = '0;
                  res_in.slot             = sccr_pkg::SLOT_W'(cur_idx);
                  res_in.writeback_valid  = 1'b1;
                  res_in.writeback_sector = rd_ent.tag;
                  pend_in  = 1'b1;
                  k_in     = k_ff + sccr_pkg::RES_CNT_W'(1);
                  idx_in   = idx_ff + sccr_pkg::CNT_W'(1);
                  state_in = S_FL_READ;
               end
            end
         end

         S_FL_END: begin
            if (item_ff.func == sccr_pkg::FUNC_FLUSH_INV && !remain_ff) begin
               valid_in = '0;
               used_in  = '0;
            end
            if (!pend_ff) begin
               res_in = '0;
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            emit_valid     = 1'b1;
            emit_data.last = 1'b1;
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      mem_wr_data = wr_ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         idx_ff    <= '0;
         used_ff   <= '0;
         valid_ff  <= '0;
         pass_ff   <= 1'b0;
         k_ff      <= '0;
         remain_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         used_ff   <= used_in;
         valid_ff  <= valid_in;
         pass_ff   <= pass_in;
         k_ff      <= k_in;
         remain_ff <= remain_in;
         pend_ff   <= pend_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
      if (mem_rd_en) begin
         rd_valid_ff <= valid_ff[mem_rd_addr];
      end
   end

   // Reads and writes never share a cycle, so no forwarding path is needed.
   `SCCR_NEVER(a_no_rd_wr_overlap, clock, reset, mem_wr_en && mem_rd_en)
   `SCCR_ASSERT(a_used_bound, clock, reset, used_ff <= sccr_pkg::CNT_W'(sccr_pkg::ENTRIES))
   `SCCR_ASSERT(a_flush_cap, clock, reset, k_ff <= sccr_pkg::RES_CNT_W'(sccr_pkg::MAX_RESULTS))
   `SCCR_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)
   `SCCR_ASSERT(a_emit_needs_result, clock, reset, emit_valid && !emit_data.last |-> pend_ff)

endmodule

`default_nettype wire

FILE: sv/sector_cache_clock_replacement_top.sv
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement_top
// Fully associative sector tag store with second-chance (clock) replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the req_ stream (tuser = function code, tdata = sector
//   and mark_dirty). Results leave on the rsp_ stream; tlast marks the final
//   result of a command. Lookup and release give one result; a flush gives
//   one result per dirty entry written back, or one empty result.
//   Commands are handled one at a time. The tag memory is read one entry at
//   a time, a read state and a check state per entry: a lookup scans from
//   slot 0 up to the hit, a miss scans every used entry, a miss on a full
//   store then runs a victim search of up to two passes over all entries,
//   and a flush scans every used entry; a receiver stall pauses a flush.
//   The next command is accepted in the cycle after the last result has gone
//   into the output register, even if the receiver has not yet taken it.
//   Reset clears pin, accessed and dirty state at once through per-entry
//   valid bits; there is no clearing pass. When the receiver stalls, the
//   output register holds its item and the scan pauses before it produces
//   another result.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_clock_replacement_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // sector[31:0], mark_dirty[32], zero pad
   input  wire logic [1:0]  req_tuser,  // func[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // hit[0], slot[6:1], fill_needed[7],
                                        // writeback_valid[8],
                                        // writeback_sector[40:9], zero pad
   output logic [1:0]       rsp_tuser,  // status[1:0]
   output logic             rsp_tlast
);

   sccr_pkg::req_type    req_item;
   sccr_pkg::result_type emit_data;
   sccr_pkg::result_type rsp_data;
   logic                 emit_valid;
   logic                 emit_ready;

   logic                             mem_wr_en;
   logic [sccr_pkg::IDX_W-1:0]       mem_wr_addr;
   logic [sccr_pkg::ENTRY_W-1:0]     mem_wr_data;
   logic                             mem_rd_en;
   logic [sccr_pkg::IDX_W-1:0]       mem_rd_addr;
   logic [sccr_pkg::ENTRY_W-1:0]     mem_rd_data;

   always_comb begin
      req_item.func       = sccr_pkg::func_type'(req_tuser);
      req_item.sector     = req_tdata[31:0];
      req_item.mark_dirty = req_tdata[32];
   end

   // Tag, pin count, accessed and dirty bits of every entry in one memory.
   sccr_ram #(
      .WIDTH (sccr_pkg::ENTRY_W),
      .DEPTH (sccr_pkg::ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sccr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_item    (req_item),
      .emit_valid  (emit_valid),
      .emit_ready  (emit_ready),
      .emit_data   (emit_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   sccr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit_valid),
      .in_ready  (emit_ready),
      .in_data   (emit_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {7'b0, rsp_data.writeback_sector, rsp_data.writeback_valid,
                       rsp_data.fill_needed, rsp_data.slot, rsp_data.hit};
   assign rsp_tuser = rsp_data.status;
   assign rsp_tlast = rsp_data.last;

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sector cache with clock replacement. Commands
// are driven on the request stream and every accepted one is run through a
// behavioral copy of the tag store. Each response is checked field by field
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   // The bench allows generously for the slowest legal run. A victim search
   // can scan every entry twice, a full flush sends 64 items, and the
   // receiver may stall most cycles or hold off for a long stretch.
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned POOL_SIZE   = 96;
   localparam int unsigned HOLD_LEN    = 400;
   localparam int unsigned DRAIN_WAIT  = 300;

   // -------------------------------------------------------------------------
   // Scoreboard: a behavioral copy of the tag store plus the queue of
   // responses that the block still owes.
   // -------------------------------------------------------------------------
   class tag_store_scoreboard;
      bit [sccr_pkg::SECTOR_W-1:0] tags[sccr_pkg::ENTRIES];
      bit [sccr_pkg::PIN_W-1:0]    pin_counts[sccr_pkg::ENTRIES];
      bit                          accessed[sccr_pkg::ENTRIES];
      bit                          dirty[sccr_pkg::ENTRIES];
      int unsigned                 used_count;
      sccr_pkg::result_type        due_responses[$];
      int unsigned                 errors;
      int unsigned                 checked;

      task report(input string msg);
         $display("tb: mismatch on response %0d: %s", checked, msg);
         errors++;
      endtask

      function int find_sector(input bit [sccr_pkg::SECTOR_W-1:0] sec);
         for (int i = 0; i < used_count; i++)
            if (tags[i] == sec)
               return i;
         return -1;
      endfunction

      // Second chance: the first pass clears accessed bits of unpinned
      // entries, so the second pass always finds one unless all are pinned.
      function int second_chance_victim();
         for (int pass = 0; pass < 2; pass++)
            for (int i = 0; i < sccr_pkg::ENTRIES; i++) begin
               if (pin_counts[i] != 0)
                  continue;
               if (accessed[i])
                  accessed[i] = 1'b0;
               else
                  return i;
            end
         return -1;
      endfunction

      function void owe(input bit hit, input int slot, input bit fill, input bit wbv,
                        input bit [sccr_pkg::SECTOR_W-1:0] wbs,
                        input sccr_pkg::status_type st, input bit last);
         sccr_pkg::result_type r;
         r = '0;
         r.hit              = hit;
         r.slot             = sccr_pkg::SLOT_W'(slot);
         r.fill_needed      = fill;
         r.writeback_valid  = wbv;
         r.writeback_sector = wbs;
         r.status           = st;
         r.last             = last;
         due_responses.push_back(r);
      endfunction

      function void note_command(input sccr_pkg::func_type f,
                                 input bit [sccr_pkg::SECTOR_W-1:0] sec, input bit md);
         int s;
         int k;
         bit wbv;
         bit remain;
         bit [sccr_pkg::SECTOR_W-1:0] wbs;
         wbv    = 1'b0;
         wbs    = '0;
         k      = 0;
         remain = 1'b0;
         case (f)
            sccr_pkg::FUNC_LOOKUP: begin
               s = find_sector(sec);
               if (s >= 0) begin
                  if (pin_counts[s] != sccr_pkg::PIN_MAX)
                     pin_counts[s]++;
                  accessed[s] = 1'b1;
                  dirty[s]    = dirty[s] | md;
                  owe(1'b1, s, 1'b0, 1'b0, '0, sccr_pkg::STATUS_OK, 1'b1);
                  return;
               end
               if (used_count < sccr_pkg::ENTRIES) begin
                  s = used_count;
                  used_count++;
               end else begin
                  s = second_chance_victim();
                  if (s < 0) begin
                     owe(1'b0, 0, 1'b0, 1'b0, '0, sccr_pkg::STATUS_ALL_PINNED, 1'b1);
                     return;
                  end
                  if (dirty[s]) begin
                     wbv = 1'b1;
                     wbs = tags[s];
                  end
               end
               tags[s]       = sec;
               pin_counts[s] = sccr_pkg::PIN_W'(1);
               accessed[s]   = 1'b1;
               dirty[s]      = md;
               owe(1'b0, s, 1'b1, wbv, wbs, sccr_pkg::STATUS_OK, 1'b1);
            end
            sccr_pkg::FUNC_RELEASE: begin
               s = find_sector(sec);
               if (s < 0) begin
                  owe(1'b0, 0, 1'b0, 1'b0, '0, sccr_pkg::STATUS_RELEASE_MISS, 1'b1);
                  return;
               end
               if (pin_counts[s] != 0)
                  pin_counts[s]--;
               owe(1'b1, s, 1'b0, 1'b0, '0, sccr_pkg::STATUS_OK, 1'b1);
            end
            default: begin
               // Both flush flavors write back dirty entries in slot order.
               for (int i = 0; i < used_count; i++) begin
                  if (!dirty[i])
                     continue;
                  if (k >= sccr_pkg::MAX_RESULTS) begin
                     remain = 1'b1;
                     break;
                  end
                  owe(1'b0, i, 1'b0, 1'b1, tags[i], sccr_pkg::STATUS_OK, 1'b0);
                  dirty[i] = 1'b0;
                  k++;
               end
               if (f == sccr_pkg::FUNC_FLUSH_INV && !remain) begin
                  used_count = 0;
                  for (int i = 0; i < sccr_pkg::ENTRIES; i++) begin
                     pin_counts[i] = '0;
                     accessed[i]   = 1'b0;
                     dirty[i]      = 1'b0;
                  end
               end
               if (k == 0)
                  owe(1'b0, 0, 1'b0, 1'b0, '0, sccr_pkg::STATUS_OK, 1'b1);
               else
                  due_responses[due_responses.size() - 1].last = 1'b1;
            end
         endcase
      endfunction

      task check_response(input sccr_pkg::result_type got);
         sccr_pkg::result_type want;
         if (due_responses.size() == 0) begin
            report("response with none outstanding");
         end else begin
            want = due_responses.pop_front();
            if (got.hit !== want.hit)
               report($sformatf("hit %0b, want %0b", got.hit, want.hit));
            if (got.slot !== want.slot)
               report($sformatf("slot %0d, want %0d", got.slot, want.slot));
            if (got.fill_needed !== want.fill_needed)
               report($sformatf("fill_needed %0b, want %0b",
                                got.fill_needed, want.fill_needed));
            if (got.writeback_valid !== want.writeback_valid)
               report($sformatf("writeback_valid %0b, want %0b",
                                got.writeback_valid, want.writeback_valid));
            if (got.writeback_sector !== want.writeback_sector)
               report($sformatf("writeback_sector %h, want %h",
                                got.writeback_sector, want.writeback_sector));
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.last !== want.last)
               report($sformatf("last %0b, want %0b", got.last, want.last));
         end
         checked++;
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // sector[31:0], mark_dirty[32], zero pad
   logic [1:0]  req_tuser  = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // hit[0], slot[6:1], fill_needed[7],
                                   // writeback_valid[8], writeback_sector[40:9]
   logic [1:0]  rsp_tuser;         // status[1:0]
   logic        rsp_tlast;

   // Idle rates in percent for each side, and a pending receiver hold-off.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned hold_cycles  = 0;

   logic [sccr_pkg::SECTOR_W-1:0] sector_pool[POOL_SIZE];

   tag_store_scoreboard sb = new;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   sector_cache_clock_replacement_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // -------------------------------------------------------------------------
   // Receiver. Ready is redrawn every cycle at the current idle rate. When the
   // stimulus asks for a hold-off, ready stays low for that many cycles while
   // the sender keeps offering commands, so the output register fills and the
   // block stops taking input.
   // -------------------------------------------------------------------------
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Responses are sampled at the edge where they are taken; the values seen
   // here are the ones that stood before the edge.
   always @(posedge clock) begin
      sccr_pkg::result_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.hit              = rsp_tdata[0];
         got.slot             = rsp_tdata[6:1];
         got.fill_needed      = rsp_tdata[7];
         got.writeback_valid  = rsp_tdata[8];
         got.writeback_sector = rsp_tdata[40:9];
         got.status           = sccr_pkg::status_type'(rsp_tuser);
         got.last             = rsp_tlast;
         sb.check_response(got);
      end
   end

   // -------------------------------------------------------------------------
   // Sender. A command may be preceded by a random gap; valid is only dropped
   // when a gap is taken, so back-to-back commands keep valid high.
   // -------------------------------------------------------------------------
   task automatic send_command(input sccr_pkg::func_type f,
                               input logic [sccr_pkg::SECTOR_W-1:0] sec, input logic md);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      if (req_tvalid !== 1'b1)
         req_tvalid <= 1'b1;
      req_tdata <= {7'b0, md, sec};
      req_tuser <= f;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_command(f, sec, md);
   endtask

   // A sector that is currently pinned, so that releases mostly do real work
   // and the store does not stay pinned solid.
   function automatic logic [sccr_pkg::SECTOR_W-1:0] pinned_sector();
      int unsigned start;
      int unsigned s;
      if (sb.used_count == 0)
         return $urandom;
      start = $urandom_range(sb.used_count - 1);
      for (int unsigned i = 0; i < sb.used_count; i++) begin
         s = (start + i) % sb.used_count;
         if (sb.pin_counts[s] != 0)
            return sb.tags[s];
      end
      return $urandom;
   endfunction

   // Random traffic over a pool larger than the store, so that it fills up
   // and victim searches run. Releases mostly target pinned entries, a few
   // pick any pool sector, and a few lookups use sectors from outside the pool
   // as noise. Full invalidation is rare so that the store spends most time full.
   task automatic send_random(input int unsigned count);
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 55)
            send_command(sccr_pkg::FUNC_LOOKUP,
                         sector_pool[$urandom_range(POOL_SIZE - 1)],
                         1'($urandom_range(1)));
         else if (pick < 85)
            send_command(sccr_pkg::FUNC_RELEASE, pinned_sector(),
                         1'($urandom_range(1)));
         else if (pick < 89)
            send_command(sccr_pkg::FUNC_RELEASE,
                         sector_pool[$urandom_range(POOL_SIZE - 1)],
                         1'($urandom_range(1)));
         else if (pick < 93)
            send_command(sccr_pkg::FUNC_LOOKUP, $urandom, 1'($urandom_range(1)));
         else if (pick < 99)
            send_command(sccr_pkg::FUNC_FLUSH, $urandom, 1'($urandom_range(1)));
         else
            send_command(sccr_pkg::FUNC_FLUSH_INV, $urandom, 1'($urandom_range(1)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Watchdog: a stuck handshake or a missing response ends the run here.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: errors");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed part runs with a slow receiver.
      req_idle_pct = 9;
      rsp_idle_pct = 82;

      // Fills in slot order at the sector extremes, then a dirtying hit.
      send_command(sccr_pkg::FUNC_LOOKUP, 32'h0000_0000, 1'b0);
      send_command(sccr_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1);
      send_command(sccr_pkg::FUNC_LOOKUP, 32'h0000_0000, 1'b1);
      // Release down to zero pins, one more release of the now unpinned
      // entry, and a release of a sector that is not cached.
      send_command(sccr_pkg::FUNC_RELEASE, 32'h0000_0000, 1'b0);
      send_command(sccr_pkg::FUNC_RELEASE, 32'h0000_0000, 1'b1);
      send_command(sccr_pkg::FUNC_RELEASE, 32'h0000_0000, 1'b0);
      send_command(sccr_pkg::FUNC_RELEASE, 32'h5A5A_A5A5, 1'b0);
      // A flush with two write-backs, then one with nothing to write back.
      send_command(sccr_pkg::FUNC_FLUSH, 32'h0000_0000, 1'b0);
      send_command(sccr_pkg::FUNC_FLUSH, 32'hFFFF_FFFF, 1'b1);
      send_command(sccr_pkg::FUNC_FLUSH_INV, 32'h0000_0000, 1'b0);

      // Fill every slot with odd slots dirty. All entries are then pinned, so
      // a miss reports that. After one release, the next miss finds only
      // accessed entries on the first pass and takes the released one on the
      // second, writing back its dirty sector.
      for (int i = 0; i < sccr_pkg::ENTRIES; i++)
         send_command(sccr_pkg::FUNC_LOOKUP, 32'h1000_0000 + i, i[0]);
      send_command(sccr_pkg::FUNC_LOOKUP, 32'h2000_0000, 1'b1);
      send_command(sccr_pkg::FUNC_RELEASE, 32'h1000_0005, 1'b0);
      send_command(sccr_pkg::FUNC_LOOKUP, 32'h2000_0001, 1'b0);
      // Invalidation with many write-backs empties the store.
      send_command(sccr_pkg::FUNC_FLUSH_INV, 32'hFFFF_FFFF, 1'b1);

      foreach (sector_pool[i])
         sector_pool[i] = $urandom;

      // Random traffic, first with a slow receiver, then with a slow sender.
      send_random(67);
      req_idle_pct = 82;
      rsp_idle_pct = 9;
      send_random(67);

      // Neither side idles, apart from one long receiver hold-off at the
      // start that backs the block up against its input.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_cycles  = HOLD_LEN;
      send_random(68);

      @(posedge clock);
      req_tvalid <= 1'b0;

      while (sb.due_responses.size() != 0)
         @(posedge clock);
      // Anything the block sends after this point is unexpected.
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
